@@ rtl/kvt_pkg.sv @@
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and sizes for the key-value table: table depth, index and
// count widths, and the operation codes.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // table geometry
  localparam int DEPTH  = 256;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 9;
  localparam int DATA_W = 32;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_ADD     = 2'd0,
    FUNC_SEARCH  = 2'd1,
    FUNC_REMOVE  = 2'd2,
    FUNC_REPLACE = 2'd3
  } func_t;

endpackage

@@ rtl/kvt_req_if.sv @@
// ----------------------------------------------------------------------------
// kvt_req_if
// Request channel of the key-value table: operation, key and the two values,
// moved with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface kvt_req_if;

  logic                               valid;
  logic                               ready;
  kvt_pkg::func_t                     func;
  logic signed [kvt_pkg::DATA_W-1:0]  key;
  logic signed [kvt_pkg::DATA_W-1:0]  new_value;
  logic signed [kvt_pkg::DATA_W-1:0]  expected_value;

  modport source (output valid, func, key, new_value, expected_value, input ready);
  modport sink   (input valid, func, key, new_value, expected_value, output ready);

endinterface

@@ rtl/kvt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// kvt_rsp_if
// Response channel of the key-value table: previous value, hit and full
// flags and the entry count, moved with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface kvt_rsp_if;

  logic                               valid;
  logic                               ready;
  logic signed [kvt_pkg::DATA_W-1:0]  old_value;
  logic                               hit;
  logic                               full_res;
  logic [kvt_pkg::CNT_W-1:0]          count;

  modport source (output valid, old_value, hit, full_res, count, input ready);
  modport sink   (input valid, old_value, hit, full_res, count, output ready);

endinterface

@@ rtl/key_value_table.sv @@
// ----------------------------------------------------------------------------
// key_value_table
// Unordered key-value table of up to 256 signed key/value pairs, searched
// linearly by one key comparator.
//
// Requests arrive on in_req (valid/ready); a word is taken when both are
// high. Operations: add, search, remove (last entry fills the hole) and
// conditional replace. Each request yields exactly one response word on
// out_rsp: the value held before the request (or the null value on a miss),
// hit, full (add of a new key to a full table) and the entry count after it.
// The null value is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, which the block does not enforce. A request is
// taken in idle; the scan then compares one stored entry per cycle until the
// key is found (at least one compare on an empty table); a remove hit passes
// through ST_MOVE_RD and ST_MOVE_WR; then the response is offered. The scan
// rate is set by the single read port of the key and value RAMs.
// in_req.ready is low from the accepted request until its response is taken;
// a stalled receiver simply holds the response. After reset the table is
// empty and the null value is zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_value_table (
  input  logic                              clk,
  input  logic                              rst_n,
  kvt_req_if.sink                           in_req,
  kvt_rsp_if.source                         out_rsp,
  input  logic                              cfg_wr_en,
  input  logic signed [kvt_pkg::DATA_W-1:0] cfg_wr_data
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_MOVE_RD = 5'b00100,
    ST_MOVE_WR = 5'b01000,
    ST_RESP    = 5'b10000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [kvt_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic [kvt_pkg::IDX_W-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic [kvt_pkg::IDX_W-1:0]          slot_r, slot_nxt;
  logic signed [kvt_pkg::DATA_W-1:0]  null_r;
  kvt_pkg::func_t                     func_r;
  logic signed [kvt_pkg::DATA_W-1:0]  key_r, new_val_r, exp_val_r;
  logic signed [kvt_pkg::DATA_W-1:0]  old_r, old_nxt;
  logic                               hit_r, hit_nxt;
  logic                               full_r, full_nxt;

  logic [kvt_pkg::IDX_W-1:0]          rd_addr;
  logic [kvt_pkg::DATA_W-1:0]         key_q, val_q;
  logic                               key_we, val_we;
  logic [kvt_pkg::IDX_W-1:0]          key_wa, val_wa;
  logic [kvt_pkg::DATA_W-1:0]         key_wd, val_wd;

  logic                               accept;
  logic                               match;
  logic                               last;
  logic                               miss;
  logic                               is_full;
  logic [kvt_pkg::CNT_W-1:0]          last_slot;

  // storage
  kvt_ram #(.WIDTH(kvt_pkg::DATA_W), .DEPTH(kvt_pkg::DEPTH)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (key_wa),
    .wr_data (key_wd),
    .rd_addr (rd_addr),
    .rd_data (key_q)
  );

  kvt_ram #(.WIDTH(kvt_pkg::DATA_W), .DEPTH(kvt_pkg::DEPTH)) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_wa),
    .wr_data (val_wd),
    .rd_addr (rd_addr),
    .rd_data (val_q)
  );

  // handshakes and scan status
  assign accept    = in_req.valid && in_req.ready;
  assign in_req.ready = rst_n && (state_r == ST_IDLE);
  assign last_slot = count_r - kvt_pkg::CNT_W'(1);
  assign match     = (count_r != '0) && (key_q == $unsigned(key_r));
  assign last      = ({1'b0, cmp_idx_r} == last_slot);
  assign miss      = (count_r == '0) || (!match && last);
  assign is_full   = (count_r == kvt_pkg::CNT_W'(kvt_pkg::DEPTH));

  // response word
  assign out_rsp.valid     = (state_r == ST_RESP);
  assign out_rsp.old_value = old_r;
  assign out_rsp.hit       = hit_r;
  assign out_rsp.full_res  = full_r;
  assign out_rsp.count     = count_r;

  // sequencer, read address and write ports
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cmp_idx_nxt = cmp_idx_r;
    slot_nxt    = slot_r;
    old_nxt     = old_r;
    hit_nxt     = hit_r;
    full_nxt    = full_r;
    rd_addr     = cmp_idx_r + kvt_pkg::IDX_W'(1);
    key_we      = 1'b0;
    val_we      = 1'b0;
    key_wa      = cmp_idx_r;
    val_wa      = cmp_idx_r;
    key_wd      = $unsigned(key_r);
    val_wd      = $unsigned(new_val_r);
    case (state_r)
      ST_IDLE: begin
        rd_addr = '0;
        if (accept) begin
          cmp_idx_nxt = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmp_idx_nxt = cmp_idx_r + kvt_pkg::IDX_W'(1);
        if (match || miss) begin
          hit_nxt   = match;
          old_nxt   = match ? $signed(val_q) : null_r;
          full_nxt  = (func_r == kvt_pkg::FUNC_ADD) && !match && is_full;
          slot_nxt  = cmp_idx_r;
          state_nxt = ST_RESP;
          case (func_r)
            kvt_pkg::FUNC_ADD: begin
              if (match) begin
                val_we = 1'b1;
              end else if (!is_full) begin
                // append at the end of the occupied slots
                key_we    = 1'b1;
                val_we    = 1'b1;
                key_wa    = count_r[kvt_pkg::IDX_W-1:0];
                val_wa    = count_r[kvt_pkg::IDX_W-1:0];
                count_nxt = count_r + kvt_pkg::CNT_W'(1);
              end
            end
            kvt_pkg::FUNC_REMOVE: begin
              if (match) begin
                state_nxt = ST_MOVE_RD;
              end
            end
            kvt_pkg::FUNC_REPLACE: begin
              val_we = match && (val_q == $unsigned(exp_val_r));
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOVE_RD: begin
        // fetch the last entry
        rd_addr   = last_slot[kvt_pkg::IDX_W-1:0];
        state_nxt = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        // last entry fills the freed slot
        key_we    = 1'b1;
        val_we    = 1'b1;
        key_wa    = slot_r;
        val_wa    = slot_r;
        key_wd    = key_q;
        val_wd    = val_q;
        count_nxt = last_slot;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_rsp.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      null_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        null_r <= cfg_wr_data;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    slot_r    <= slot_nxt;
    old_r     <= old_nxt;
    hit_r     <= hit_nxt;
    full_r    <= full_nxt;
    if (accept) begin
      func_r    <= in_req.func;
      key_r     <= in_req.key;
      new_val_r <= in_req.new_value;
      exp_val_r <= in_req.expected_value;
    end
  end

endmodule

@@ rtl/kvt_ram.sv @@
// ----------------------------------------------------------------------------
// kvt_ram
// Generic single-write, single-read RAM with a registered read port.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module kvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ dv/key_value_table_tb.sv @@
// ----------------------------------------------------------------------------
// key_value_table_tb
// Self-checking bench for the key-value table. A driver feeds request words
// from a backlog and a monitor checks every response word against a local
// model of the table's slots, count and null value. A directed opening is
// followed by random phases: mixed operations on a small key pool, a fill
// of the whole table with work on the full table, and a closing stretch
// with no idling. The null value is rewritten between phases.
// ----------------------------------------------------------------------------
module key_value_table_tb;

  typedef struct packed {
    kvt_pkg::func_t                    func;
    logic signed [kvt_pkg::DATA_W-1:0] key;
    logic signed [kvt_pkg::DATA_W-1:0] new_value;
    logic signed [kvt_pkg::DATA_W-1:0] expected_value;
    bit                                drain;
  } req_word_t;

  typedef struct packed {
    logic signed [kvt_pkg::DATA_W-1:0] old_value;
    logic                              hit;
    logic                              full_res;
    logic [kvt_pkg::CNT_W-1:0]         count;
  } rsp_word_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_wr_en;
  logic signed [kvt_pkg::DATA_W-1:0] cfg_wr_data;

  kvt_req_if in_req ();
  kvt_rsp_if out_rsp ();

  key_value_table i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .out_rsp     (out_rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // local copy of the table
  logic signed [kvt_pkg::DATA_W-1:0] tbl_key [kvt_pkg::DEPTH];
  logic signed [kvt_pkg::DATA_W-1:0] tbl_val [kvt_pkg::DEPTH];
  int                                tbl_count = 0;
  logic signed [kvt_pkg::DATA_W-1:0] tbl_null  = '0;

  req_word_t                req_backlog [$];
  rsp_word_t                rsp_due [$];
  rsp_word_t                due_word;
  req_word_t                next_req;
  int                       req_sent  = 0;
  int                       req_taken = 0;
  int                       send_gap  = 0;
  int                       stall_left = 0;
  bit                       idle_on   = 1'b1;
  int                       err_cnt   = 0;

  logic signed [kvt_pkg::DATA_W-1:0] key_pool [12];
  logic signed [kvt_pkg::DATA_W-1:0] val_pool [4];
  logic signed [kvt_pkg::DATA_W-1:0] fill_keys [$];
  logic signed [kvt_pkg::DATA_W-1:0] fill_vals [$];

  always #6 clk = ~clk;

  // apply one request to the local table and return the word it should give
  function automatic rsp_word_t table_apply(kvt_pkg::func_t f,
                                            logic signed [kvt_pkg::DATA_W-1:0] k,
                                            logic signed [kvt_pkg::DATA_W-1:0] nv,
                                            logic signed [kvt_pkg::DATA_W-1:0] ev);
    rsp_word_t res;
    bit        found;
    int        slot;
    int        last;
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (!found && tbl_key[i] == k) begin
        found = 1'b1;
        slot  = i;
      end
    end
    res.old_value = found ? tbl_val[slot] : tbl_null;
    res.hit       = found;
    res.full_res  = 1'b0;
    case (f)
      kvt_pkg::FUNC_ADD: begin
        if (found) begin
          tbl_val[slot] = nv;
        end else if (tbl_count < kvt_pkg::DEPTH) begin
          tbl_key[tbl_count] = k;
          tbl_val[tbl_count] = nv;
          tbl_count++;
        end else begin
          res.full_res = 1'b1;
        end
      end
      kvt_pkg::FUNC_REMOVE: begin
        if (found) begin
          last          = tbl_count - 1;
          tbl_key[slot] = tbl_key[last];
          tbl_val[slot] = tbl_val[last];
          tbl_count     = last;
        end
      end
      kvt_pkg::FUNC_REPLACE: begin
        if (found && res.old_value == ev) tbl_val[slot] = nv;
      end
      default: ;
    endcase
    res.count = kvt_pkg::CNT_W'(tbl_count);
    return res;
  endfunction

  // key neither stored nor among the fill keys
  function automatic bit is_fresh(logic signed [kvt_pkg::DATA_W-1:0] k);
    for (int i = 0; i < tbl_count; i++) if (tbl_key[i] == k) return 1'b0;
    foreach (fill_keys[i]) if (fill_keys[i] == k) return 1'b0;
    return 1'b1;
  endfunction

  function automatic kvt_pkg::func_t pick_func();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return kvt_pkg::FUNC_ADD;
    if (r < 6) return kvt_pkg::FUNC_SEARCH;
    if (r < 8) return kvt_pkg::FUNC_REMOVE;
    return kvt_pkg::FUNC_REPLACE;
  endfunction

  function automatic logic signed [kvt_pkg::DATA_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  function automatic logic signed [kvt_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return val_pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  function automatic void queue_req(kvt_pkg::func_t f,
                                    logic signed [kvt_pkg::DATA_W-1:0] k,
                                    logic signed [kvt_pkg::DATA_W-1:0] nv,
                                    logic signed [kvt_pkg::DATA_W-1:0] ev, bit drain);
    req_word_t w;
    w.func           = f;
    w.key            = k;
    w.new_value      = nv;
    w.expected_value = ev;
    w.drain          = drain;
    req_backlog.push_back(w);
  endfunction

  function automatic void queue_mixed(int n);
    for (int i = 0; i < n; i++)
      queue_req(pick_func(), pick_key(), pick_value(), pick_value(),
                $urandom_range(0, 19) == 0);
  endfunction

  task automatic report(string name, longint exp_v, longint act_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    err_cnt++;
  endtask

  // request driver: one word on offer at a time, bursts of idle between words
  always @(negedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (req_taken != req_sent) begin
      // word on offer, hold it
    end else if (send_gap > 0) begin
      in_req.valid <= 1'b0;
      send_gap     <= send_gap - 1;
    end else if (req_backlog.size() != 0 && (!req_backlog[0].drain || rsp_due.size() == 0)) begin
      next_req              = req_backlog.pop_front();
      in_req.valid          <= 1'b1;
      in_req.func           <= next_req.func;
      in_req.key            <= next_req.key;
      in_req.new_value      <= next_req.new_value;
      in_req.expected_value <= next_req.expected_value;
      req_sent              <= req_sent + 1;
      if (idle_on && $urandom_range(0, 2) == 0) send_gap <= $urandom_range(1, 19);
    end else begin
      in_req.valid <= 1'b0;
    end
  end

  // response ready with stall bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_rsp.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      out_rsp.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 19);
    end
  end

  // check response words, then predict from accepted request words
  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (rsp_due.size() == 0) begin
        $display("%0t: response word with none expected, actual old_value %0d hit %0b count %0d",
                 $time, out_rsp.old_value, out_rsp.hit, out_rsp.count);
        err_cnt++;
      end else begin
        due_word = rsp_due.pop_front();
        if (out_rsp.old_value !== due_word.old_value)
          report("old_value", due_word.old_value, out_rsp.old_value);
        if (out_rsp.hit !== due_word.hit) report("hit", due_word.hit, out_rsp.hit);
        if (out_rsp.full_res !== due_word.full_res)
          report("full_res", due_word.full_res, out_rsp.full_res);
        if (out_rsp.count !== due_word.count) report("count", due_word.count, out_rsp.count);
      end
    end
    if (rst_n && in_req.valid && in_req.ready) begin
      rsp_due.push_back(table_apply(in_req.func, in_req.key, in_req.new_value,
                                    in_req.expected_value));
      req_taken <= req_taken + 1;
    end
  end

  // wait until every word has gone through and been answered
  task automatic wait_idle();
    do @(posedge clk);
    while (req_backlog.size() != 0 || req_taken != req_sent || rsp_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_null(logic signed [kvt_pkg::DATA_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    tbl_null    = v;
  endtask

  // fill the table to the brim, then work on the full table
  task automatic fill_phase();
    logic signed [kvt_pkg::DATA_W-1:0] k;
    int                                need;
    int                                j;
    need = kvt_pkg::DEPTH - tbl_count;
    while (fill_keys.size() < need) begin
      k = $urandom;
      if (is_fresh(k)) begin
        fill_keys.push_back(k);
        fill_vals.push_back($urandom);
        queue_req(kvt_pkg::FUNC_ADD, k, fill_vals[$], $urandom, 1'b0);
      end
    end
    // adds of new keys to a full table are refused
    repeat (3) begin
      do k = $urandom; while (!is_fresh(k));
      queue_req(kvt_pkg::FUNC_ADD, k, $urandom, $urandom, 1'b0);
    end
    queue_req(kvt_pkg::FUNC_ADD, fill_keys[0], $urandom, $urandom, 1'b0);
    queue_req(kvt_pkg::FUNC_ADD, fill_keys[need-1], $urandom, $urandom, 1'b0);
    queue_req(kvt_pkg::FUNC_REPLACE, fill_keys[need/2], $urandom, fill_vals[need/2], 1'b0);
    queue_req(kvt_pkg::FUNC_REPLACE, fill_keys[need/3], $urandom, ~fill_vals[need/3], 1'b0);
    queue_req(kvt_pkg::FUNC_SEARCH, fill_keys[need/4], $urandom, $urandom, 1'b0);
    queue_req(kvt_pkg::FUNC_REMOVE, fill_keys[1], $urandom, $urandom, 1'b1);
    repeat (2) begin
      do k = $urandom; while (!is_fresh(k));
      fill_keys.push_back(k);
      queue_req(kvt_pkg::FUNC_ADD, k, $urandom, $urandom, 1'b0);
    end
    repeat (19) begin
      j = $urandom_range(0, fill_keys.size() - 1);
      queue_req(pick_func(), fill_keys[j], $urandom, $urandom, $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    in_req.valid          = 1'b0;
    in_req.func           = kvt_pkg::FUNC_SEARCH;
    in_req.key            = '0;
    in_req.new_value      = '0;
    in_req.expected_value = '0;
    out_rsp.ready         = 1'b0;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    rst_n                 = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening with the largest null value
    set_null(32'sh7fff_ffff);
    queue_req(kvt_pkg::FUNC_SEARCH,  32'sd0, 32'sd1, 32'sd2, 1'b0);
    queue_req(kvt_pkg::FUNC_REMOVE,  32'sd5, 32'sd1, 32'sd2, 1'b0);
    queue_req(kvt_pkg::FUNC_REPLACE, 32'sd5, 32'sd1, 32'sd0, 1'b0);
    queue_req(kvt_pkg::FUNC_ADD,     32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, 1'b0);
    queue_req(kvt_pkg::FUNC_ADD,     32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, 1'b0);
    queue_req(kvt_pkg::FUNC_ADD,     32'sd0, 32'sd0, 32'sh7fff_ffff, 1'b0);
    queue_req(kvt_pkg::FUNC_ADD,     -32'sd1, -32'sd1, -32'sd1, 1'b0);
    queue_req(kvt_pkg::FUNC_SEARCH,  32'sh8000_0000, 32'sd0, 32'sd0, 1'b0);
    queue_req(kvt_pkg::FUNC_ADD,     32'sd0, 32'sd123, 32'sd0, 1'b0);
    queue_req(kvt_pkg::FUNC_REPLACE, 32'sd0, -32'sd1, 32'sd123, 1'b0);
    queue_req(kvt_pkg::FUNC_REPLACE, 32'sd0, 32'sd7, 32'sd5, 1'b0);
    queue_req(kvt_pkg::FUNC_SEARCH,  32'sd0, 32'sd0, 32'sd0, 1'b0);
    queue_req(kvt_pkg::FUNC_REMOVE,  32'sh7fff_ffff, 32'sd0, 32'sd0, 1'b0);
    queue_req(kvt_pkg::FUNC_REMOVE,  -32'sd1, 32'sd0, 32'sd0, 1'b0);
    queue_req(kvt_pkg::FUNC_SEARCH,  -32'sd1, 32'sd0, 32'sd0, 1'b0);
    queue_req(kvt_pkg::FUNC_REMOVE,  32'sd0, 32'sd0, 32'sd0, 1'b0);
    queue_req(kvt_pkg::FUNC_REMOVE,  32'sh8000_0000, 32'sd0, 32'sd0, 1'b1);
    queue_req(kvt_pkg::FUNC_ADD,     32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 1'b0);
    queue_req(kvt_pkg::FUNC_ADD,     32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b0);
    queue_req(kvt_pkg::FUNC_REPLACE, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 32'sh5555_5555, 1'b0);
    queue_req(kvt_pkg::FUNC_SEARCH,  32'sh5555_5555, 32'sh0f0f_0f0f, 32'sd0, 1'b0);
    queue_req(kvt_pkg::FUNC_SEARCH,  32'shaaaa_aaaa, 32'sd0, 32'sd0, 1'b0);
    wait_idle();

    // mixed operations on a small key pool, smallest null value
    key_pool = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    val_pool = '{32'sd0, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000};
    set_null(32'sh8000_0000);
    queue_mixed(120);
    wait_idle();

    // whole table filled, random null value
    set_null($urandom);
    fill_phase();
    wait_idle();

    // closing stretch with neither side idling
    set_null(32'sd0);
    idle_on = 1'b0;
    wait (stall_left == 0 && send_gap == 0);
    queue_mixed(80);
    wait_idle();
    repeat (20) @(posedge clk);

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #12_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
